### rtl/core/lnpm_pkg.sv
// Shared types, codes and the microprogram of the linked-list node pool manager.
`default_nettype none

package lnpm_pkg;

  // Field widths of the command and result words.
  localparam int CMD_W     = 2;
  localparam int LIST_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 4;
  localparam int REMOVED_W = 5;

  // A read returns at most this many elements.
  localparam int MAX_RESULTS = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TAIL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ELEM  = 2'd2;

  // Datapath operation carried by a control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_RD_FREE,
    OP_ALLOC,
    OP_HEAD,
    OP_WALK,
    OP_TAIL_TERM,
    OP_TAIL_LINK,
    OP_DGET,
    OP_DSTEP,
    OP_DUNLINK,
    OP_DFREE,
    OP_RSTART,
    OP_RSTEP
  } op_e;

  // Jump condition carried by a control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_START,
    C_FREE_NIL,
    C_IS_HEAD,
    C_WALK_MORE,
    C_DSTOP,
    C_NOMATCH,
    C_FIRST_NIL,
    C_RMORE
  } cond_e;

  // Result word issued by a control word.
  typedef enum logic [2:0] {
    E_NONE,
    E_DONE,
    E_EMPTY,
    E_INS,
    E_DEL,
    E_ELEM
  } emit_e;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    emit_e emit;
    step_t target;
  } ucode_t;

  // Enables from the sequencer to the node store.
  typedef struct packed {
    logic rd;
    logic ptr_wr;
    logic byte_wr;
  } store_ctl_t;

  // Program addresses.
  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_BAD    = 5'd1;
  localparam step_t S_EMPTY  = 5'd2;
  localparam step_t S_INS    = 5'd3;
  localparam step_t S_ALLOC  = 5'd4;
  localparam step_t S_WALK   = 5'd5;
  localparam step_t S_TTERM  = 5'd6;
  localparam step_t S_TLINK  = 5'd7;
  localparam step_t S_HEAD   = 5'd8;
  localparam step_t S_DEL    = 5'd9;
  localparam step_t S_DSTEP  = 5'd10;
  localparam step_t S_DUNL   = 5'd11;
  localparam step_t S_DFREE  = 5'd12;
  localparam step_t S_DEND   = 5'd13;
  localparam step_t S_READ   = 5'd14;
  localparam step_t S_RSTEP  = 5'd15;
  localparam step_t S_RTAIL  = 5'd16;

  // The microprogram. A taken condition jumps to target, otherwise the
  // next step follows; the idle step waits on itself for a command.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, emit: E_NONE, target: S_IDLE};
    case (step)
      S_IDLE:  w = '{op: OP_IDLE,      cond: C_START,     emit: E_NONE,  target: S_IDLE};
      S_BAD:   w = '{op: OP_NOP,       cond: C_ALWAYS,    emit: E_DONE,  target: S_IDLE};
      S_EMPTY: w = '{op: OP_NOP,       cond: C_ALWAYS,    emit: E_EMPTY, target: S_IDLE};
      S_INS:   w = '{op: OP_RD_FREE,   cond: C_FREE_NIL,  emit: E_NONE,  target: S_EMPTY};
      S_ALLOC: w = '{op: OP_ALLOC,     cond: C_IS_HEAD,   emit: E_NONE,  target: S_HEAD};
      S_WALK:  w = '{op: OP_WALK,      cond: C_WALK_MORE, emit: E_NONE,  target: S_WALK};
      S_TTERM: w = '{op: OP_TAIL_TERM, cond: C_NEVER,     emit: E_NONE,  target: S_IDLE};
      S_TLINK: w = '{op: OP_TAIL_LINK, cond: C_ALWAYS,    emit: E_INS,   target: S_IDLE};
      S_HEAD:  w = '{op: OP_HEAD,      cond: C_ALWAYS,    emit: E_INS,   target: S_IDLE};
      S_DEL:   w = '{op: OP_DGET,      cond: C_DSTOP,     emit: E_NONE,  target: S_DEND};
      S_DSTEP: w = '{op: OP_DSTEP,     cond: C_NOMATCH,   emit: E_NONE,  target: S_DEL};
      S_DUNL:  w = '{op: OP_DUNLINK,   cond: C_NEVER,     emit: E_NONE,  target: S_IDLE};
      S_DFREE: w = '{op: OP_DFREE,     cond: C_ALWAYS,    emit: E_NONE,  target: S_DEL};
      S_DEND:  w = '{op: OP_NOP,       cond: C_ALWAYS,    emit: E_DEL,   target: S_IDLE};
      S_READ:  w = '{op: OP_RSTART,    cond: C_FIRST_NIL, emit: E_NONE,  target: S_BAD};
      S_RSTEP: w = '{op: OP_RSTEP,     cond: C_RMORE,     emit: E_ELEM,  target: S_RSTEP};
      S_RTAIL: w = '{op: OP_NOP,       cond: C_ALWAYS,    emit: E_NONE,  target: S_IDLE};
      default: w = '{op: OP_NOP,       cond: C_ALWAYS,    emit: E_NONE,  target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/linked_list_node_pool_manager_top.sv
// Top level of the linked-list node pool manager: microcoded sequencer and datapath.
`default_nettype none

// A pool of NODE_COUNT nodes, each holding a byte and a next link, is shared by
// LIST_COUNT singly linked lists; unused nodes sit on a free list that works as
// a stack, the first allocation after reset taking the highest index. A command
// word is taken when start_i is high and busy_o is low. Every command gives one
// or more result words, each shown for exactly one cycle with result_valid_o
// high; the receiver cannot hold them off, so it must take one every cycle that
// the strobe is set. The final word of a command carries last_o. Every link is
// followed through the single registered read port of the node store, and a
// read gives one result word per cycle. The final result word appears in the
// cycle after the last busy cycle, except for a read of a list that holds
// elements, whose final element is shown during its last busy cycle.
module linked_list_node_pool_manager_top #(
  parameter int NODE_COUNT = 16,
  parameter int LIST_COUNT = 4
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  output logic                              busy_o,
  input  wire [lnpm_pkg::CMD_W-1:0]         command_i,
  input  wire [lnpm_pkg::LIST_W-1:0]        list_id_i,
  input  wire [lnpm_pkg::BYTE_W-1:0]        value_i,
  output logic                              result_valid_o,
  output logic [lnpm_pkg::STATUS_W-1:0]     status_o,
  output logic [lnpm_pkg::BYTE_W-1:0]       element_o,
  output logic [lnpm_pkg::INDEX_W-1:0]      node_index_o,
  output logic [lnpm_pkg::REMOVED_W-1:0]    removed_o,
  output logic                              last_o
);

  // Links are wide enough to hold NODE_COUNT, so that NODE_COUNT can stand
  // for the null link.
  localparam int PW = $clog2(NODE_COUNT + 1);
  localparam int SW = $clog2(NODE_COUNT + 1);
  localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int RD_LIMIT = (NODE_COUNT < lnpm_pkg::MAX_RESULTS) ?
                            NODE_COUNT : lnpm_pkg::MAX_RESULTS;
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

  // Sequencer.
  lnpm_pkg::step_t  step_q, step_d, dispatch;
  lnpm_pkg::ucode_t uw;
  logic             accept, cond_ok;

  // Datapath registers.
  logic [lnpm_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [lnpm_pkg::LIST_W-1:0] list_q, list_d;
  logic [lnpm_pkg::BYTE_W-1:0] val_q, val_d;
  logic [PW-1:0]               pos_q, pos_d, nxt_q, nxt_d, node_q, node_d;
  logic [PW-1:0]               free_q, free_d;
  logic [SW-1:0]               steps_q, steps_d, cnt_q, cnt_d;
  logic [PW-1:0]               first_q [LIST_COUNT];
  logic                        lf_we;
  logic [PW-1:0]               lf_data;

  // Node store access.
  lnpm_pkg::store_ctl_t        st_ctl;
  logic [PW-1:0]               rd_addr, ptr_wr_addr, ptr_wr_data, byte_wr_addr;
  logic [PW-1:0]               nn_ptr;
  logic [lnpm_pkg::BYTE_W-1:0] nb_byte;

  // Derived values.
  logic [LW-1:0]  lsel;
  logic [PW-1:0]  first, lk;
  logic           lk_live, match, rd_end;
  logic [SW:0]    steps_nx;

  // Result word.
  logic                              res_valid_d;
  logic [lnpm_pkg::STATUS_W-1:0]     status_d;
  logic [lnpm_pkg::BYTE_W-1:0]       element_d;
  logic [lnpm_pkg::INDEX_W-1:0]      index_d;
  logic [lnpm_pkg::REMOVED_W-1:0]    removed_d;
  logic                              last_d;
  logic [PW+lnpm_pkg::INDEX_W-1:0]   pos_ext, node_ext;
  logic [SW+lnpm_pkg::REMOVED_W-1:0] cnt_ext;

  lnpm_node_store #(
    .NODE_COUNT (NODE_COUNT)
  ) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (st_ctl),
    .rd_addr_i      (rd_addr),
    .ptr_wr_addr_i  (ptr_wr_addr),
    .ptr_wr_data_i  (ptr_wr_data),
    .byte_wr_addr_i (byte_wr_addr),
    .byte_wr_data_i (val_q),
    .ptr_rd_o       (nn_ptr),
    .byte_rd_o      (nb_byte)
  );

  assign uw     = lnpm_pkg::ucode_rom(step_q);
  assign busy_o = (step_q != lnpm_pkg::S_IDLE);
  assign accept = start_i && !busy_o;

  // The link that follows pos: the list head when pos is null, otherwise the
  // link of pos as last read from the store.
  assign lsel     = LW'(list_q);
  assign first    = first_q[lsel];
  assign lk       = (pos_q == NIL) ? first : nn_ptr;
  assign lk_live  = (lk < NIL);
  assign match    = (nb_byte == val_q);
  assign steps_nx = {1'b0, steps_q} + 1'b1;
  // A read stops on the tail, on the result bound or on the walk bound.
  assign rd_end   = (nn_ptr >= NIL) || (steps_nx >= (SW+1)'(RD_LIMIT));

  always_comb begin
    if (int'(list_id_i) >= LIST_COUNT) begin
      dispatch = lnpm_pkg::S_BAD;
    end else begin
      case (command_i)
        lnpm_pkg::CMD_TAIL: dispatch = lnpm_pkg::S_INS;
        lnpm_pkg::CMD_HEAD: dispatch = lnpm_pkg::S_INS;
        lnpm_pkg::CMD_DEL:  dispatch = lnpm_pkg::S_DEL;
        lnpm_pkg::CMD_READ: dispatch = lnpm_pkg::S_READ;
        default:            dispatch = lnpm_pkg::S_BAD;
      endcase
    end
  end

  // Jump condition of the current control word.
  always_comb begin
    case (uw.cond)
      lnpm_pkg::C_NEVER:     cond_ok = 1'b0;
      lnpm_pkg::C_ALWAYS:    cond_ok = 1'b1;
      lnpm_pkg::C_START:     cond_ok = accept;
      lnpm_pkg::C_FREE_NIL:  cond_ok = (free_q >= NIL);
      lnpm_pkg::C_IS_HEAD:   cond_ok = (cmd_q == lnpm_pkg::CMD_HEAD);
      lnpm_pkg::C_WALK_MORE: cond_ok = lk_live && (steps_nx < (SW+1)'(NODE_COUNT));
      lnpm_pkg::C_DSTOP:     cond_ok = !lk_live || (steps_q >= SW'(NODE_COUNT));
      lnpm_pkg::C_NOMATCH:   cond_ok = !match;
      lnpm_pkg::C_FIRST_NIL: cond_ok = (first >= NIL);
      lnpm_pkg::C_RMORE:     cond_ok = !rd_end;
      default:               cond_ok = 1'b0;
    endcase
  end

  // Next step: jump, fall through, or wait in the idle step.
  always_comb begin
    if (cond_ok) begin
      step_d = (uw.cond == lnpm_pkg::C_START) ? dispatch : uw.target;
    end else if (uw.cond == lnpm_pkg::C_START) begin
      step_d = step_q;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Datapath operations.
  always_comb begin
    cmd_d        = cmd_q;
    list_d       = list_q;
    val_d        = val_q;
    pos_d        = pos_q;
    nxt_d        = nxt_q;
    node_d       = node_q;
    free_d       = free_q;
    steps_d      = steps_q;
    cnt_d        = cnt_q;
    lf_we        = 1'b0;
    lf_data      = node_q;
    st_ctl       = '0;
    rd_addr      = pos_q;
    ptr_wr_addr  = pos_q;
    ptr_wr_data  = node_q;
    byte_wr_addr = free_q;
    case (uw.op)
      lnpm_pkg::OP_IDLE: begin
        if (accept) begin
          cmd_d   = command_i;
          list_d  = list_id_i;
          val_d   = value_i;
          pos_d   = NIL;
          steps_d = '0;
          cnt_d   = '0;
        end
      end
      lnpm_pkg::OP_RD_FREE: begin
        st_ctl.rd = 1'b1;
        rd_addr   = free_q;
      end
      lnpm_pkg::OP_ALLOC: begin
        node_d         = free_q;
        free_d         = nn_ptr;
        st_ctl.byte_wr = 1'b1;
      end
      lnpm_pkg::OP_HEAD: begin
        st_ctl.ptr_wr = 1'b1;
        ptr_wr_addr   = node_q;
        ptr_wr_data   = first;
        lf_we         = 1'b1;
      end
      lnpm_pkg::OP_WALK: begin
        if (lk_live) begin
          pos_d     = lk;
          steps_d   = steps_nx[SW-1:0];
          st_ctl.rd = 1'b1;
          rd_addr   = lk;
        end
      end
      lnpm_pkg::OP_TAIL_TERM: begin
        st_ctl.ptr_wr = 1'b1;
        ptr_wr_addr   = node_q;
        ptr_wr_data   = NIL;
      end
      lnpm_pkg::OP_TAIL_LINK: begin
        if (pos_q == NIL) begin
          lf_we = 1'b1;
        end else begin
          st_ctl.ptr_wr = 1'b1;
        end
      end
      lnpm_pkg::OP_DGET: begin
        nxt_d     = lk;
        st_ctl.rd = 1'b1;
        rd_addr   = lk;
      end
      lnpm_pkg::OP_DSTEP: begin
        if (!match) begin
          pos_d     = nxt_q;
          steps_d   = steps_nx[SW-1:0];
          st_ctl.rd = 1'b1;
          rd_addr   = nxt_q;
        end
      end
      lnpm_pkg::OP_DUNLINK: begin
        // Bypass the matching node: its own link was read in the fetch step.
        lf_data     = nn_ptr;
        ptr_wr_data = nn_ptr;
        if (pos_q == NIL) begin
          lf_we = 1'b1;
        end else begin
          st_ctl.ptr_wr = 1'b1;
        end
      end
      lnpm_pkg::OP_DFREE: begin
        // Push the unlinked node and refetch the link after pos.
        st_ctl.ptr_wr = 1'b1;
        ptr_wr_addr   = nxt_q;
        ptr_wr_data   = free_q;
        free_d        = nxt_q;
        cnt_d         = cnt_q + 1'b1;
        steps_d       = steps_nx[SW-1:0];
        st_ctl.rd     = 1'b1;
        rd_addr       = pos_q;
      end
      lnpm_pkg::OP_RSTART: begin
        pos_d     = first;
        st_ctl.rd = 1'b1;
        rd_addr   = first;
      end
      lnpm_pkg::OP_RSTEP: begin
        pos_d     = nn_ptr;
        steps_d   = steps_nx[SW-1:0];
        st_ctl.rd = 1'b1;
        rd_addr   = nn_ptr;
      end
      default: begin
      end
    endcase
  end

  // Result word for the current step; it is registered and shown next cycle.
  assign pos_ext  = {{lnpm_pkg::INDEX_W{1'b0}}, pos_q};
  assign node_ext = {{lnpm_pkg::INDEX_W{1'b0}}, node_q};
  assign cnt_ext  = {{lnpm_pkg::REMOVED_W{1'b0}}, cnt_q};

  always_comb begin
    res_valid_d = 1'b1;
    status_d    = lnpm_pkg::ST_DONE;
    element_d   = '0;
    index_d     = '0;
    removed_d   = '0;
    last_d      = 1'b1;
    case (uw.emit)
      lnpm_pkg::E_NONE:  res_valid_d = 1'b0;
      lnpm_pkg::E_DONE:  status_d    = lnpm_pkg::ST_DONE;
      lnpm_pkg::E_EMPTY: status_d    = lnpm_pkg::ST_EMPTY;
      lnpm_pkg::E_INS:   index_d     = node_ext[lnpm_pkg::INDEX_W-1:0];
      lnpm_pkg::E_DEL:   removed_d   = cnt_ext[lnpm_pkg::REMOVED_W-1:0];
      lnpm_pkg::E_ELEM: begin
        status_d  = lnpm_pkg::ST_ELEM;
        element_d = nb_byte;
        index_d   = pos_ext[lnpm_pkg::INDEX_W-1:0];
        last_d    = rd_end;
      end
      default:           res_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= lnpm_pkg::S_IDLE;
      free_q         <= PW'(NODE_COUNT - 1);
      result_valid_o <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        first_q[i] <= NIL;
      end
    end else begin
      step_q         <= step_d;
      free_q         <= free_d;
      result_valid_o <= res_valid_d;
      if (lf_we) begin
        first_q[lsel] <= lf_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    list_q       <= list_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    nxt_q        <= nxt_d;
    node_q       <= node_d;
    steps_q      <= steps_d;
    cnt_q        <= cnt_d;
    status_o     <= status_d;
    element_o    <= element_d;
    node_index_o <= index_d;
    removed_o    <= removed_d;
    last_o       <= last_d;
  end

endmodule

`default_nettype wire

### rtl/core/lnpm_node_store.sv
// Node store: next links with reset values through valid bits, and node bytes.
`default_nettype none

module lnpm_node_store #(
  parameter int NODE_COUNT = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire lnpm_pkg::store_ctl_t    ctl_i,
  input  wire [$clog2(NODE_COUNT+1)-1:0] rd_addr_i,
  input  wire [$clog2(NODE_COUNT+1)-1:0] ptr_wr_addr_i,
  input  wire [$clog2(NODE_COUNT+1)-1:0] ptr_wr_data_i,
  input  wire [$clog2(NODE_COUNT+1)-1:0] byte_wr_addr_i,
  input  wire [lnpm_pkg::BYTE_W-1:0]   byte_wr_data_i,
  output logic [$clog2(NODE_COUNT+1)-1:0] ptr_rd_o,
  output logic [lnpm_pkg::BYTE_W-1:0]  byte_rd_o
);

  localparam int PW = $clog2(NODE_COUNT + 1);
  localparam int IW = $clog2(NODE_COUNT);
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

  logic [PW-1:0]               ptr_mem [NODE_COUNT];
  logic [lnpm_pkg::BYTE_W-1:0] byte_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]       vld_q;

  logic          rd_hit, ptr_hit, byte_hit;
  logic [PW-1:0] ptr_q, addr_q;
  logic          rd_vld_q;

  assign rd_hit   = ctl_i.rd      && (rd_addr_i      < NIL);
  assign ptr_hit  = ctl_i.ptr_wr  && (ptr_wr_addr_i  < NIL);
  assign byte_hit = ctl_i.byte_wr && (byte_wr_addr_i < NIL);

  // A link that was never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ptr_hit) begin
      vld_q[ptr_wr_addr_i[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ptr_hit) begin
      ptr_mem[ptr_wr_addr_i[IW-1:0]] <= ptr_wr_data_i;
    end
    if (byte_hit) begin
      byte_mem[byte_wr_addr_i[IW-1:0]] <= byte_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_hit) begin
      ptr_q     <= ptr_mem[rd_addr_i[IW-1:0]];
      byte_rd_o <= byte_mem[rd_addr_i[IW-1:0]];
      rd_vld_q  <= vld_q[rd_addr_i[IW-1:0]];
      addr_q    <= rd_addr_i;
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      ptr_rd_o = ptr_q;
    end else if (addr_q == '0) begin
      ptr_rd_o = NIL;
    end else begin
      ptr_rd_o = addr_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

### bench/tb_linked_list_node_pool_manager_top.sv
// Self-checking testbench for the linked-list node pool manager, with its own pool predictor.
module tb_linked_list_node_pool_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The pool is modelled at the default size of the block. Null links are
  // encoded as the node count, exactly one beyond the highest node index.
  localparam int NODES = 16;
  localparam int LISTS = 4;
  localparam logic [4:0] NIL = 5'd16;
  localparam int CLK_HALF = 10;
  // The slowest command is a delete that frees all sixteen nodes. The limit
  // on cycles in which no word moves is set far above that delete and above
  // the longest sender gap.
  localparam int IDLE_LIMIT = 2000;
  // Settling time after the last expected word, longer than any command.
  localparam int SETTLE_CYCLES = 80;

  // One result word as the block presents it.
  typedef struct packed {
    logic [lnpm_pkg::STATUS_W-1:0]  status;
    logic [lnpm_pkg::BYTE_W-1:0]    element;
    logic [lnpm_pkg::INDEX_W-1:0]   node_index;
    logic [lnpm_pkg::REMOVED_W-1:0] removed;
    logic                           last;
  } result_word_t;

  // Clock, reset and the stimulus side of the interface. Every input is
  // given a known value from time zero.
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic [lnpm_pkg::CMD_W-1:0]     command = lnpm_pkg::CMD_READ;
  logic [lnpm_pkg::LIST_W-1:0]    list_id = '0;
  logic [lnpm_pkg::BYTE_W-1:0]    value = '0;

  logic                           busy;
  logic                           result_valid;
  logic [lnpm_pkg::STATUS_W-1:0]  status;
  logic [lnpm_pkg::BYTE_W-1:0]    element;
  logic [lnpm_pkg::INDEX_W-1:0]   node_index;
  logic [lnpm_pkg::REMOVED_W-1:0] removed;
  logic                           last;

  // Predicted pool contents: node bytes, next links, list heads and the top
  // of the free stack.
  logic [lnpm_pkg::BYTE_W-1:0] pool_byte [NODES];
  logic [4:0]                  pool_link [NODES];
  logic [4:0]                  list_head [LISTS];
  logic [4:0]                  free_top;

  // Words still to come from the block, oldest first.
  result_word_t awaited_words[$];

  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  always #CLK_HALF clk = ~clk;

  linked_list_node_pool_manager_top #(
    .NODE_COUNT(NODES),
    .LIST_COUNT(LISTS)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .command_i     (command),
    .list_id_i     (list_id),
    .value_i       (value),
    .result_valid_o(result_valid),
    .status_o      (status),
    .element_o     (element),
    .node_index_o  (node_index),
    .removed_o     (removed),
    .last_o        (last)
  );

  // ---------------------------------------------------------------------
  // Pool predictor
  // ---------------------------------------------------------------------

  // After reset every node is free, node i linking to node i-1, so the first
  // allocation takes the highest index. Bytes start at zero but are always
  // written before a list can reach them.
  function automatic void pool_reset();
    for (int i = 0; i < NODES; i++) begin
      pool_byte[4'(i)] = '0;
      pool_link[4'(i)] = (i == 0) ? NIL : 5'(i - 1);
    end
    for (int l = 0; l < LISTS; l++) begin
      list_head[2'(l)] = NIL;
    end
    free_top = 5'(NODES - 1);
  endfunction

  function automatic void await_word(input logic [lnpm_pkg::STATUS_W-1:0] st,
                                     input logic [lnpm_pkg::BYTE_W-1:0] elem,
                                     input logic [lnpm_pkg::INDEX_W-1:0] idx,
                                     input logic [lnpm_pkg::REMOVED_W-1:0] freed,
                                     input logic fin);
    result_word_t w;
    w.status     = st;
    w.element    = elem;
    w.node_index = idx;
    w.removed    = freed;
    w.last       = fin;
    awaited_words.push_back(w);
  endfunction

  // The link that follows pos; a position of null stands for the list head.
  function automatic logic [4:0] link_after(input logic [lnpm_pkg::LIST_W-1:0] lst,
                                            input logic [4:0] pos);
    if (pos == NIL) begin
      return list_head[lst];
    end
    return pool_link[pos[3:0]];
  endfunction

  function automatic void relink(input logic [lnpm_pkg::LIST_W-1:0] lst,
                                 input logic [4:0] pos,
                                 input logic [4:0] target);
    if (pos == NIL) begin
      list_head[lst] = target;
    end else begin
      pool_link[pos[3:0]] = target;
    end
  endfunction

  // Applies one accepted command word to the predicted pool and queues the
  // result words it must cause.
  function automatic void pool_command(input logic [lnpm_pkg::CMD_W-1:0] cmd,
                                       input logic [lnpm_pkg::LIST_W-1:0] lst_id,
                                       input logic [lnpm_pkg::BYTE_W-1:0] val);
    int         lst;
    int         k;
    logic [4:0] pos;
    logic [4:0] nxt;
    logic [4:0] node;
    logic [4:0] freed;
    logic       stop;
    lst = int'(lst_id);
    // A list number beyond the configured count leaves the pool alone and gives a single done word.
    if (lst >= LISTS) begin
      await_word(lnpm_pkg::ST_DONE, '0, '0, '0, 1'b1);
      return;
    end
    case (cmd)
      lnpm_pkg::CMD_TAIL, lnpm_pkg::CMD_HEAD: begin
        if (free_top >= NIL) begin
          // Pool exhausted: the insert is dropped and flagged.
          await_word(lnpm_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          node = free_top;
          free_top = pool_link[node[3:0]];
          pool_byte[node[3:0]] = val;
          if (cmd == lnpm_pkg::CMD_HEAD) begin
            pool_link[node[3:0]] = list_head[lst_id];
            list_head[lst_id] = node;
          end else begin
            pos = NIL;
            for (int s = 0; s < NODES; s++) begin
              nxt = link_after(lst_id, pos);
              if (nxt >= NIL) break;
              pos = nxt;
            end
            pool_link[node[3:0]] = NIL;
            relink(lst_id, pos, node);
          end
          await_word(lnpm_pkg::ST_DONE, '0, node[lnpm_pkg::INDEX_W-1:0], '0, 1'b1);
        end
      end
      lnpm_pkg::CMD_DEL: begin
        // Matching nodes go onto the free stack in the order they are unlinked.
        freed = '0;
        pos = NIL;
        for (int s = 0; s < NODES; s++) begin
          nxt = link_after(lst_id, pos);
          if (nxt >= NIL) break;
          if (pool_byte[nxt[3:0]] == val) begin
            relink(lst_id, pos, pool_link[nxt[3:0]]);
            pool_link[nxt[3:0]] = free_top;
            free_top = nxt;
            freed++;
          end else begin
            pos = nxt;
          end
        end
        await_word(lnpm_pkg::ST_DONE, '0, '0, freed, 1'b1);
      end
      default: begin
        pos = list_head[lst_id];
        if (pos >= NIL) begin
          // An empty list reads out as a single done word.
          await_word(lnpm_pkg::ST_DONE, '0, '0, '0, 1'b1);
        end else begin
          k = 0;
          for (int s = 0; s < NODES && k < lnpm_pkg::MAX_RESULTS; s++) begin
            nxt = pool_link[pos[3:0]];
            stop = (nxt >= NIL) || (k + 1 >= lnpm_pkg::MAX_RESULTS) || (s + 1 >= NODES);
            await_word(lnpm_pkg::ST_ELEM, pool_byte[pos[3:0]],
                       pos[lnpm_pkg::INDEX_W-1:0], '0, stop);
            k++;
            if (stop) break;
            pos = nxt;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // The receiver cannot hold words off, so every strobed cycle is taken.
  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && result_valid) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected result word: status %0d element %0d node %0d removed %0d last %0d",
               status, element, node_index, removed, last);
        fail_count++;
      end else begin
        want = awaited_words.pop_front();
        check_field("status", want.status, status);
        check_field("element", want.element, element);
        check_field("node_index", want.node_index, node_index);
        check_field("removed", want.removed, removed);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog: counts cycles in which no word moves in either direction.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || result_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Sends one command word. The sender works in bursts: when a burst runs
  // out, it idles for a random number of cycles and draws a new burst
  // length, occasionally a long one so that some stretches have no gaps.
  // Start is lowered at the falling edge after acceptance and raised again
  // no earlier than the next falling edge, so it is never assigned twice in
  // one time step. While start is low the fields carry random noise.
  task automatic send_word(input logic [lnpm_pkg::CMD_W-1:0] cmd,
                           input logic [lnpm_pkg::LIST_W-1:0] lst,
                           input logic [lnpm_pkg::BYTE_W-1:0] val);
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    start   <= 1'b1;
    command <= cmd;
    list_id <= lst;
    value   <= val;
    do @(posedge clk); while (busy);
    pool_command(cmd, lst, val);
    burst_left--;
    @(negedge clk);
    start   <= 1'b0;
    command <= lnpm_pkg::CMD_W'($urandom);
    list_id <= lnpm_pkg::LIST_W'($urandom);
    value   <= lnpm_pkg::BYTE_W'($urandom);
  endtask

  // Holds the sender off until every expected word has been seen.
  task automatic wait_for_results();
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // Bytes are mostly drawn from a small set so that deletes find matches,
  // with the extremes of the byte among them.
  function automatic logic [lnpm_pkg::BYTE_W-1:0] pick_byte();
    logic [lnpm_pkg::BYTE_W-1:0] common [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    if ($urandom_range(0, 3) == 0) begin
      return lnpm_pkg::BYTE_W'($urandom);
    end
    return common[2'($urandom_range(0, 3))];
  endfunction

  // Every command on small lists, with the extreme byte values, a delete
  // with no match and a delete on an empty list.
  task automatic test_basic_ops();
    send_word(lnpm_pkg::CMD_READ, 2'd3, 8'h00);
    send_word(lnpm_pkg::CMD_HEAD, 2'd0, 8'h00);
    send_word(lnpm_pkg::CMD_TAIL, 2'd0, 8'hFF);
    send_word(lnpm_pkg::CMD_HEAD, 2'd0, 8'hFF);
    send_word(lnpm_pkg::CMD_TAIL, 2'd1, 8'hAA);
    send_word(lnpm_pkg::CMD_READ, 2'd0, 8'hFF);
    send_word(lnpm_pkg::CMD_DEL,  2'd0, 8'hFF);
    send_word(lnpm_pkg::CMD_DEL,  2'd2, 8'h00);
    send_word(lnpm_pkg::CMD_DEL,  2'd1, 8'h55);
  endtask

  // Frees the whole pool, puts every node into one list, then tries inserts
  // on the exhausted pool, reads the full list so that the read bound ends
  // it, and deletes it again in two passes.
  task automatic test_pool_bound();
    send_word(lnpm_pkg::CMD_DEL, 2'd0, 8'h00);
    send_word(lnpm_pkg::CMD_DEL, 2'd1, 8'hAA);
    for (int i = 0; i < NODES; i++) begin
      send_word((i % 2 == 0) ? lnpm_pkg::CMD_TAIL : lnpm_pkg::CMD_HEAD, 2'd2,
                (i % 4 == 0) ? 8'hC3 : 8'h3C);
    end
    send_word(lnpm_pkg::CMD_TAIL, 2'd2, 8'h11);
    send_word(lnpm_pkg::CMD_HEAD, 2'd3, 8'hEE);
    send_word(lnpm_pkg::CMD_READ, 2'd2, 8'h00);
    send_word(lnpm_pkg::CMD_DEL,  2'd2, 8'h3C);
    send_word(lnpm_pkg::CMD_DEL,  2'd2, 8'hC3);
  endtask

  // Random traffic. The insert share steers the pool towards exhaustion or
  // towards empty lists; the rest is split between deletes and reads.
  task automatic test_random_traffic(input int count, input int insert_share);
    int                          r;
    logic [lnpm_pkg::CMD_W-1:0]  cmd;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_share) begin
        cmd = ($urandom_range(0, 1) == 0) ? lnpm_pkg::CMD_TAIL : lnpm_pkg::CMD_HEAD;
      end else if (r < insert_share + (100 - insert_share) / 2) begin
        cmd = lnpm_pkg::CMD_DEL;
      end else begin
        cmd = lnpm_pkg::CMD_READ;
      end
      send_word(cmd, lnpm_pkg::LIST_W'($urandom), pick_byte());
    end
  endtask

  // Reset is released on a falling edge; the tests then run in turn, with a
  // full pause before the second and the fourth random phases.
  initial begin
    pool_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_pool_bound();
    test_random_traffic(80, 75);
    wait_for_results();
    test_random_traffic(80, 35);
    test_random_traffic(90, 60);
    wait_for_results();
    test_random_traffic(90, 50);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
